FILE: sv/primality_trial_division_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the primality tester.
// Clocked implication checks, disabled while the active-low reset is low.
// ---------------------------------------------------------------------------
`ifndef PRIMALITY_TRIAL_DIVISION_ASSERT_SVH
`define PRIMALITY_TRIAL_DIVISION_ASSERT_SVH

// Same-cycle implication.
`define PTD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("primality tester check failed");

// Next-cycle implication.
`define PTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("primality tester check failed");

`endif

FILE: sv/ptd_pkg.sv
// ---------------------------------------------------------------------------
// ptd_pkg
// Widths and shared types of the trial-division primality tester.
// ---------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

    localparam int DATA_WIDTH = 32;
    // Magnitude of a positive input (sign bit dropped).
    localparam int MAG_W      = DATA_WIDTH - 1;
    // Trial divisors never exceed floor(sqrt(max)) + 1.
    localparam int DIV_W      = (MAG_W + 1) / 2 + 1;
    // Step counter of the radix-2 divider.
    localparam int CNT_W      = $clog2(MAG_W);

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } t_div_rsp;

endpackage

`default_nettype wire

FILE: sv/ptd_div.sv
// ---------------------------------------------------------------------------
// ptd_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ptd_div
    import ptd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [MAG_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_dvs;

    logic [DIV_W:0]   rem_sh;
    logic [DIV_W+1:0] diff;
    logic             fits;
    logic [MAG_W-1:0] n_quo;
    logic [DIV_W-1:0] n_rem;

    // The dividend shifts out of the top of r_quo while quotient bits enter below.
    always_comb begin
        rem_sh = {r_rem, r_quo[MAG_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_dvs};
        fits   = ~diff[DIV_W+1];
        n_quo  = {r_quo[MAG_W-2:0], fits};
        n_rem  = fits ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MAG_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

FILE: sv/primality_trial_division.sv
// ---------------------------------------------------------------------------
// primality_trial_division: trial-division primality test of a signed input.
// Values below 2 answer in the cycle after the request. Otherwise each trial
// divisor takes one pass of the shared radix-2 divider, and the test
// runs up to floor(sqrt(n)) divisors.
// busy stays high until the result strobe. Synchronous reset returns to idle.
// ---------------------------------------------------------------------------
`default_nettype none

module primality_trial_division
    import ptd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] i_number,
    output logic                  busy,
    output logic                  o_done,
    output logic                  o_is_prime
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state           r_state;
    logic             r_div_start;
    logic             r_done;
    logic             r_is_prime;
    logic [MAG_W-1:0] r_n;
    logic [DIV_W-1:0] r_d;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic accept;
    logic trivial;
    logic past_bound;

    assign accept  = start && (r_state == S_IDLE);
    // Negative, zero and one are never prime.
    assign trivial = i_number[DATA_WIDTH-1] || (i_number[MAG_W-1:1] == '0);
    // The divisor has passed sqrt(n) once it exceeds n / d.
    assign past_bound = {{(MAG_W-DIV_W){1'b0}}, r_d} > div_rsp.quotient;

    assign div_req.start    = r_div_start;
    assign div_req.dividend = r_n;
    assign div_req.divisor  = r_d;

    ptd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_done      <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (trivial) begin
                            r_done <= 1'b1;
                        end else begin
                            r_div_start <= 1'b1;
                            r_state     <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (div_rsp.done) begin
                        if (past_bound || (div_rsp.remainder == '0)) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_div_start <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_n        <= i_number[MAG_W-1:0];
            r_d        <= DIV_W'(2);
            r_is_prime <= 1'b0;
        end else if ((r_state == S_RUN) && div_rsp.done) begin
            if (past_bound) begin
                r_is_prime <= 1'b1;
            end else if (div_rsp.remainder != '0) begin
                r_d <= r_d + 1'b1;
            end
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign o_done     = r_done;
    assign o_is_prime = r_is_prime;

endmodule

`default_nettype wire

FILE: sv/ptd_chk.sv
// ---------------------------------------------------------------------------
// ptd_chk
// Port-level checks of the primality tester, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "primality_trial_division_assert.svh"

module ptd_chk
    import ptd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic [DATA_WIDTH-1:0] i_number,
    input logic                  busy,
    input logic                  o_done,
    input logic                  o_is_prime
);

    logic req_neg;
    logic req_long;

    assign req_neg  = start && !busy && i_number[DATA_WIDTH-1];
    assign req_long = start && !busy && !i_number[DATA_WIDTH-1] &&
                      (i_number[DATA_WIDTH-2:1] != '0);

    // A negative request answers "not prime" in the very next cycle.
    `PTD_ASSERT_NEXT(a_neg_fast, i_clk, i_rst_n, req_neg, o_done && !o_is_prime)
    // A value of two or more goes to the divider loop and cannot answer at once.
    `PTD_ASSERT_NEXT(a_long_busy, i_clk, i_rst_n, req_long, busy && !o_done)
    // The result strobe comes with the block already idle.
    `PTD_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    // Leaving the busy state always delivers a result.
    `PTD_ASSERT_SAME(a_fall_done, i_clk, i_rst_n, $fell(busy), o_done)

endmodule

bind primality_trial_division ptd_chk u_ptd_chk (.*);

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the trial-division primality tester
// Sends signed integers through the start/busy handshake and compares every
// o_done verdict with a trial-division prediction kept in a scoreboard. A
// directed set covers the sign, zero and one, the smallest primes, prime
// squares and the largest positive value. A random part follows, mostly
// small values so the run stays short.
// ---------------------------------------------------------------------------

module tb_top;
    import ptd_pkg::*;

    typedef logic [DATA_WIDTH-1:0] number_t;

    typedef struct {
        number_t number;
        bit      verdict;
    } verdict_t;

    class prime_verdict_board;
        verdict_t expected_verdicts[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Divisors run from 2 while d <= n / d, so the bound never overflows.
        function bit trial_division_verdict(number_t n);
            number_t d;
            if (n[DATA_WIDTH-1] || n < 2)
                return 1'b0;
            for (d = 2; d <= n / d; d++) begin
                if (n % d == 0)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_request(number_t n);
            verdict_t v;
            v.number  = n;
            v.verdict = trial_division_verdict(n);
            expected_verdicts.push_back(v);
        endfunction

        function void check_verdict(logic got);
            verdict_t want;
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("verdict %0b arrived with no request outstanding", got);
                return;
            end
            want = expected_verdicts.pop_front();
            if (got !== want.verdict) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("number %0d (0x%08h): expected is_prime %0b, got %0b",
                             $signed(want.number), want.number, want.verdict, got);
            end
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction
    endclass

    localparam number_t DIRECTED_NUMBERS [0:22] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49, 32'd97,
        32'd121, 32'd289, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000,
        32'h7FFF_FFFE, 32'h5555_5555, 32'h2AAA_AAAA, 32'd65521, 32'd65537,
        32'd999983, 32'd1022117, 32'h7FFF_FFFF
    };

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    number_t i_number;
    logic    busy;
    logic    o_done;
    logic    o_is_prime;

    prime_verdict_board verdict_book;

    primality_trial_division u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_number   (i_number),
        .busy       (busy),
        .o_done     (o_done),
        .o_is_prime (o_is_prime)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                verdict_book.note_request(i_number);
            if (o_done)
                verdict_book.check_verdict(o_is_prime);
        end
    end

    // Most values are small; large positives get a small factor so the
    // divider loop ends early. Only the directed part runs long searches.
    function automatic number_t random_number();
        int          pick;
        int unsigned k;
        int unsigned f;
        number_t     n;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            n = $urandom_range(0, 4095);
        end else if (pick < 65) begin
            n = $urandom_range(4096, 65535);
        end else if (pick < 75) begin
            k = $urandom_range(2, 255);
            n = k * k;
        end else if (pick < 88) begin
            n = $urandom | 32'h8000_0000;
        end else begin
            n = $urandom & 32'h7FFF_FFFF;
            f = $urandom_range(2, 7);
            n = n - n % f;
        end
        return n;
    endfunction

    function automatic int pick_idle(bit allowed);
        if (!allowed || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 9);
    endfunction

    // start stays high across back-to-back requests; it only drops for a gap.
    task automatic send_number(number_t n, int idle_cycles);
        if (idle_cycles > 0) begin
            start <= 1'b0;
            repeat (idle_cycles) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_number <= n;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (verdict_book.pending() != 0);
    endtask

    initial begin
        int i;
        verdict_book = new();
        i_rst_n  <= 1'b0;
        start    <= 1'b0;
        i_number <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_NUMBERS[k])
            send_number(DIRECTED_NUMBERS[k], pick_idle(1'b1));
        hold_until_drained();

        for (i = 0; i < 100; i++) begin
            send_number(random_number(), pick_idle(i < 80));
            if (i == 40)
                hold_until_drained();
        end
        hold_until_drained();
        repeat (40) @(posedge i_clk);

        if (verdict_book.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // The largest positive prime runs the longest divider search.
    initial begin
        #(120_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
